>>> design/relative_quaternion_to_euler_defines.svh
// Assertion macros for the relative quaternion to Euler block.
// Used by the checker; depends on nothing else.
`ifndef RELATIVE_QUATERNION_TO_EULER_DEFINES_SVH
`define RELATIVE_QUATERNION_TO_EULER_DEFINES_SVH

// property holds on every clock edge out of reset
`define RQE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rqe check failed");

// antecedent implies consequent on the same edge
`define RQE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rqe check failed");

`endif

>>> design/rqe_pkg.sv
// Shared types and constants for the relative quaternion to Euler block.
// No dependencies.
package rqe_pkg;

	localparam int Q_W       = 16;
	localparam int TERM_W    = 34;
	localparam int SQ_STAGES = 29;
	localparam int RAD_W     = 2 * SQ_STAGES;
	localparam int ROOT_W    = SQ_STAGES;
	localparam int REM_W     = 32;
	localparam int CX_W      = 37;
	localparam int ANG_W     = 24;
	localparam int TAB_LEN   = 24;

	typedef logic signed [Q_W-1:0]    q16_t;
	typedef logic signed [TERM_W-1:0] term_t;

	typedef enum logic [2:0] {
		REG_ZERO_W = 3'd0,
		REG_ZERO_X = 3'd1,
		REG_ZERO_Y = 3'd2,
		REG_ZERO_Z = 3'd3
	} cfg_reg_t;

	localparam logic OP_DIRECT   = 1'b0;
	localparam logic OP_RELATIVE = 1'b1;

	localparam logic signed [Q_W-1:0]    ZERO_W_RST = 16'sd16384;
	localparam logic signed [TERM_W-1:0] ONE_Q28    = 34'sd268435456;
	localparam logic signed [ANG_W-1:0]  ANG_90     = 24'sd2304000;

	localparam logic [20:0] ATAN_TAB [TAB_LEN] = '{
		21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
		21'd22916, 21'd11459, 21'd5730, 21'd2865, 21'd1432, 21'd716,
		21'd358, 21'd179, 21'd90, 21'd45, 21'd22, 21'd11,
		21'd6, 21'd3, 21'd1, 21'd1, 21'd0, 21'd0
	};

endpackage

>>> design/relative_quaternion_to_euler.sv
// Top level: relative quaternion to ZYX Euler angles, fully pipelined.
// Depends on rqe_pkg, rqe_qmul and rqe_cordic.
//
//  channel   handshake          payload
//  request   start / busy       op, hand_*, fore_*
//  result    done (one cycle)   yaw, pitch, roll, pitch_clamped
//  config    cfg_we             cfg_idx, cfg_wdata
//
// One request per cycle.
// Latency is set by two quaternion products, the 29-stage square root for
// the pitch cosine and the CORDIC_ITERS-stage CORDIC.
// busy stays low; reset clears the valid bits and loads the identity zero.
module relative_quaternion_to_euler #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  rqe_pkg::q16_t       hand_w,
	input  rqe_pkg::q16_t       hand_x,
	input  rqe_pkg::q16_t       hand_y,
	input  rqe_pkg::q16_t       hand_z,
	input  rqe_pkg::q16_t       fore_w,
	input  rqe_pkg::q16_t       fore_x,
	input  rqe_pkg::q16_t       fore_y,
	input  rqe_pkg::q16_t       fore_z,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_wdata,
	output logic                done,
	output logic signed [15:0]  yaw,
	output logic signed [14:0]  pitch,
	output logic signed [15:0]  roll,
	output logic                pitch_clamped
);
	import rqe_pkg::*;

	localparam int PD_LEN = CORDIC_ITERS + 2;

	q16_t zero_q [4];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic op_s1, op_s2, op_s3, op_s4, op_s5;
	q16_t hand_s1 [4], hand_s2 [4], hand_s3 [4], hand_s4 [4], hand_s5 [4];
	q16_t fore_s1 [4], fore_s2 [4], fore_s3 [4];
	q16_t d_s3 [4], q1_s5 [4], qs [4];

	logic signed [31:0] pr_s6 [9];
	term_t sy_s7, cy_s7, sp_s7, sr_s7, cr_s7;
	term_t sy_s8, cy_s8, sp_s8, sr_s8, cr_s8;
	logic  clamp_s8, neg_s8;
	logic [55:0] sq_s8;
	logic  sp_clamp;
	logic [27:0] sp_mag;
	term_t sp_abs;

	logic              rt_v    [SQ_STAGES+1];
	logic              rt_cl   [SQ_STAGES+1];
	logic              rt_neg  [SQ_STAGES+1];
	logic [RAD_W-1:0]  rt_rad  [SQ_STAGES+1];
	logic [REM_W-1:0]  rt_rem  [SQ_STAGES+1];
	logic [ROOT_W-1:0] rt_root [SQ_STAGES+1];
	term_t rt_sy [SQ_STAGES+1], rt_cy [SQ_STAGES+1], rt_sp [SQ_STAGES+1];
	term_t rt_sr [SQ_STAGES+1], rt_cr [SQ_STAGES+1];

	logic [1:0] pd_s [PD_LEN];
	logic       v_yaw, v_pitch, v_roll;
	logic signed [15:0] ang_pitch;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q[0] <= ZERO_W_RST;
			zero_q[1] <= '0;
			zero_q[2] <= '0;
			zero_q[3] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_ZERO_W: zero_q[0] <= cfg_wdata;
				REG_ZERO_X: zero_q[1] <= cfg_wdata;
				REG_ZERO_Y: zero_q[2] <= cfg_wdata;
				REG_ZERO_Z: zero_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op;
		hand_s1[0] <= hand_w; hand_s1[1] <= hand_x;
		hand_s1[2] <= hand_y; hand_s1[3] <= hand_z;
		fore_s1[0] <= fore_w; fore_s1[1] <= fore_x;
		fore_s1[2] <= fore_y; fore_s1[3] <= fore_z;
		op_s2 <= op_s1; op_s3 <= op_s2; op_s4 <= op_s3; op_s5 <= op_s4;
		hand_s2 <= hand_s1; hand_s3 <= hand_s2; hand_s4 <= hand_s3; hand_s5 <= hand_s4;
		fore_s2 <= fore_s1; fore_s3 <= fore_s2;
	end

	rqe_qmul u_qmul_zero (.clk(clk), .a(zero_q),  .b(hand_s1), .r(d_s3));
	rqe_qmul u_qmul_fore (.clk(clk), .a(fore_s3), .b(d_s3),    .r(q1_s5));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qs[k] = (op_s5 == OP_RELATIVE) ? q1_s5[k] : hand_s5[k];
		end
	end

	always_ff @(posedge clk) begin
		pr_s6[0] <= qs[0] * qs[3];
		pr_s6[1] <= qs[1] * qs[2];
		pr_s6[2] <= qs[2] * qs[2];
		pr_s6[3] <= qs[3] * qs[3];
		pr_s6[4] <= qs[0] * qs[2];
		pr_s6[5] <= qs[3] * qs[1];
		pr_s6[6] <= qs[0] * qs[1];
		pr_s6[7] <= qs[2] * qs[3];
		pr_s6[8] <= qs[1] * qs[1];
	end

	always_ff @(posedge clk) begin
		sy_s7 <= (TERM_W'(pr_s6[0]) + TERM_W'(pr_s6[1])) <<< 1;
		cy_s7 <= ONE_Q28 - ((TERM_W'(pr_s6[2]) + TERM_W'(pr_s6[3])) <<< 1);
		sp_s7 <= (TERM_W'(pr_s6[4]) - TERM_W'(pr_s6[5])) <<< 1;
		sr_s7 <= (TERM_W'(pr_s6[6]) + TERM_W'(pr_s6[7])) <<< 1;
		cr_s7 <= ONE_Q28 - ((TERM_W'(pr_s6[8]) + TERM_W'(pr_s6[2])) <<< 1);
	end

	assign sp_clamp = (sp_s7 >= ONE_Q28) || (sp_s7 <= -ONE_Q28);
	assign sp_abs   = sp_s7[TERM_W-1] ? -sp_s7 : sp_s7;
	assign sp_mag   = sp_clamp ? '0 : sp_abs[27:0];

	always_ff @(posedge clk) begin
		sq_s8    <= sp_mag * sp_mag;
		clamp_s8 <= sp_clamp;
		neg_s8   <= sp_s7[TERM_W-1];
		sy_s8 <= sy_s7; cy_s8 <= cy_s7; sp_s8 <= sp_s7;
		sr_s8 <= sr_s7; cr_s8 <= cr_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v[0] <= 1'b0;
		end else begin
			rt_v[0] <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		rt_rad[0]  <= RAD_W'({1'b1, 56'd0}) - RAD_W'(sq_s8);
		rt_rem[0]  <= '0;
		rt_root[0] <= '0;
		rt_cl[0]   <= clamp_s8;
		rt_neg[0]  <= neg_s8;
		rt_sy[0] <= sy_s8; rt_cy[0] <= cy_s8; rt_sp[0] <= sp_s8;
		rt_sr[0] <= sr_s8; rt_cr[0] <= cr_s8;
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		logic [REM_W-1:0] rem_in, trial;

		assign rem_in = {rt_rem[k][REM_W-3:0], rt_rad[k][RAD_W-1 -: 2]};
		assign trial  = REM_W'({rt_root[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else begin
				rt_v[k+1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_in >= trial) begin
				rt_rem[k+1]  <= rem_in - trial;
				rt_root[k+1] <= {rt_root[k][ROOT_W-2:0], 1'b1};
			end else begin
				rt_rem[k+1]  <= rem_in;
				rt_root[k+1] <= {rt_root[k][ROOT_W-2:0], 1'b0};
			end
			rt_rad[k+1] <= rt_rad[k] << 2;
			rt_cl[k+1]  <= rt_cl[k];
			rt_neg[k+1] <= rt_neg[k];
			rt_sy[k+1] <= rt_sy[k]; rt_cy[k+1] <= rt_cy[k]; rt_sp[k+1] <= rt_sp[k];
			rt_sr[k+1] <= rt_sr[k]; rt_cr[k+1] <= rt_cr[k];
		end
	end

	rqe_cordic #(.ITERS(CORDIC_ITERS)) u_cordic_yaw (
		.clk(clk), .arst_n(arst_n), .vld_i(rt_v[SQ_STAGES]),
		.y_i(rt_sy[SQ_STAGES]), .x_i(rt_cy[SQ_STAGES]),
		.vld_o(v_yaw), .ang_o(yaw)
	);

	rqe_cordic #(.ITERS(CORDIC_ITERS)) u_cordic_pitch (
		.clk(clk), .arst_n(arst_n), .vld_i(rt_v[SQ_STAGES]),
		.y_i(rt_sp[SQ_STAGES]), .x_i(TERM_W'(rt_root[SQ_STAGES])),
		.vld_o(v_pitch), .ang_o(ang_pitch)
	);

	rqe_cordic #(.ITERS(CORDIC_ITERS)) u_cordic_roll (
		.clk(clk), .arst_n(arst_n), .vld_i(rt_v[SQ_STAGES]),
		.y_i(rt_sr[SQ_STAGES]), .x_i(rt_cr[SQ_STAGES]),
		.vld_o(v_roll), .ang_o(roll)
	);

	always_ff @(posedge clk) begin
		pd_s[0] <= {rt_cl[SQ_STAGES], rt_neg[SQ_STAGES]};
		for (int k = 1; k < PD_LEN; k++) begin
			pd_s[k] <= pd_s[k-1];
		end
	end

	assign done          = v_yaw && v_pitch && v_roll;
	assign pitch_clamped = pd_s[PD_LEN-1][1];

	always_comb begin
		if (pd_s[PD_LEN-1][1])
			pitch = pd_s[PD_LEN-1][0] ? -15'sd9000 : 15'sd9000;
		else if (ang_pitch > 16'sd9000)
			pitch = 15'sd9000;
		else if (ang_pitch < -16'sd9000)
			pitch = -15'sd9000;
		else
			pitch = ang_pitch[14:0];
	end

endmodule

>>> design/rqe_qmul.sv
// Two-stage pipelined product conj(a) x b of Q2.14 quaternions.
// Depends on rqe_pkg.
module rqe_qmul (
	input  logic         clk,
	input  rqe_pkg::q16_t a [4],
	input  rqe_pkg::q16_t b [4],
	output rqe_pkg::q16_t r [4]
);
	import rqe_pkg::*;

	logic signed [16:0] an [4];
	logic signed [32:0] p_s1 [16];
	logic signed [34:0] sum [4];
	logic signed [34:0] rnd [4];

	assign an[0] = 17'(a[0]);
	assign an[1] = -17'(a[1]);
	assign an[2] = -17'(a[2]);
	assign an[3] = -17'(a[3]);

	always_ff @(posedge clk) begin
		p_s1[0]  <= an[0] * b[0];
		p_s1[1]  <= an[1] * b[1];
		p_s1[2]  <= an[2] * b[2];
		p_s1[3]  <= an[3] * b[3];
		p_s1[4]  <= an[0] * b[1];
		p_s1[5]  <= an[1] * b[0];
		p_s1[6]  <= an[2] * b[3];
		p_s1[7]  <= an[3] * b[2];
		p_s1[8]  <= an[0] * b[2];
		p_s1[9]  <= an[1] * b[3];
		p_s1[10] <= an[2] * b[0];
		p_s1[11] <= an[3] * b[1];
		p_s1[12] <= an[0] * b[3];
		p_s1[13] <= an[1] * b[2];
		p_s1[14] <= an[2] * b[1];
		p_s1[15] <= an[3] * b[0];
	end

	always_comb begin
		sum[0] = 35'(p_s1[0])  - 35'(p_s1[1])  - 35'(p_s1[2])  - 35'(p_s1[3]);
		sum[1] = 35'(p_s1[4])  + 35'(p_s1[5])  + 35'(p_s1[6])  - 35'(p_s1[7]);
		sum[2] = 35'(p_s1[8])  - 35'(p_s1[9])  + 35'(p_s1[10]) + 35'(p_s1[11]);
		sum[3] = 35'(p_s1[12]) + 35'(p_s1[13]) - 35'(p_s1[14]) + 35'(p_s1[15]);
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (sum[k] + 35'sd8192) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			if (rnd[k] > 35'sd32767)
				r[k] <= 16'sh7fff;
			else if (rnd[k] < -35'sd32768)
				r[k] <= 16'sh8000;
			else
				r[k] <= rnd[k][15:0];
		end
	end

endmodule

>>> design/rqe_cordic.sv
// Pipelined vectoring CORDIC atan2, result in hundredths of a degree.
// Depends on rqe_pkg; input, iteration and output stages are all registered.
module rqe_cordic #(
	parameter int ITERS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_i,
	input  rqe_pkg::term_t       y_i,
	input  rqe_pkg::term_t       x_i,
	output logic                 vld_o,
	output logic signed [15:0]   ang_o
);
	import rqe_pkg::*;

	logic                    v_s   [ITERS+1];
	logic                    z_s   [ITERS+1];
	logic signed [CX_W-1:0]  x_s   [ITERS+1];
	logic signed [CX_W-1:0]  y_s   [ITERS+1];
	logic signed [ANG_W-1:0] a_s   [ITERS+1];
	logic signed [CX_W-1:0]  xe, ye;
	logic signed [ANG_W-1:0] rnd;

	assign xe = CX_W'(x_i);
	assign ye = CX_W'(y_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		z_s[0] <= (x_i == '0) && (y_i == '0);
		if (x_i[TERM_W-1]) begin
			if (!y_i[TERM_W-1]) begin
				x_s[0] <= ye;
				y_s[0] <= -xe;
				a_s[0] <= ANG_90;
			end else begin
				x_s[0] <= -ye;
				y_s[0] <= xe;
				a_s[0] <= -ANG_90;
			end
		end else begin
			x_s[0] <= xe;
			y_s[0] <= ye;
			a_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < ITERS; g++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			z_s[g+1] <= z_s[g];
			if (y_s[g] > 0) begin
				x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
				a_s[g+1] <= a_s[g] + ANG_W'(ATAN_TAB[g]);
			end else begin
				x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
				a_s[g+1] <= a_s[g] - ANG_W'(ATAN_TAB[g]);
			end
		end
	end

	assign rnd = (a_s[ITERS] + 24'sd128) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= v_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (z_s[ITERS])
			ang_o <= '0;
		else if (rnd > 24'sd18000)
			ang_o <= 16'sd18000;
		else if (rnd < -24'sd18000)
			ang_o <= -16'sd18000;
		else
			ang_o <= rnd[15:0];
	end

endmodule

>>> design/rqe_checker.sv
// Port-level checks for the relative quaternion to Euler block, bound to the top.
// Depends on relative_quaternion_to_euler_defines.svh.
`include "relative_quaternion_to_euler_defines.svh"

module rqe_checker #(
	parameter int CORDIC_ITERS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] yaw,
	input logic signed [14:0] pitch,
	input logic signed [15:0] roll,
	input logic               pitch_clamped
);
	localparam int LAT = CORDIC_ITERS + 40;

	`RQE_ASSERT_IMP(a_done_has_req, clk, arst_n, done, $past(start && !busy, LAT))
	`RQE_ASSERT_IMP(a_pitch_range, clk, arst_n, done, (pitch <= 15'sd9000) && (pitch >= -15'sd9000))
	`RQE_ASSERT_IMP(a_clamp_pitch, clk, arst_n, done && pitch_clamped, (pitch == 15'sd9000) || (pitch == -15'sd9000))
	`RQE_ASSERT_IMP(a_angle_range, clk, arst_n, done, (yaw <= 16'sd18000) && (yaw >= -16'sd18000) && (roll <= 16'sd18000) && (roll >= -16'sd18000))

endmodule

bind relative_quaternion_to_euler rqe_checker #(.CORDIC_ITERS(CORDIC_ITERS)) u_rqe_checker (.*);

>>> verif/relative_quaternion_to_euler_test.sv
// Testbench for relative_quaternion_to_euler: directed and random quaternion requests,
// checked field by field against a built-in ZYX Euler/CORDIC predictor.
// Depends on rqe_pkg and the relative_quaternion_to_euler RTL.
`timescale 1ns / 1ps

module relative_quaternion_to_euler_test;
	import rqe_pkg::*;

	localparam int ITERS = 16;
	localparam int LATENCY = ITERS + 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 270;

	typedef longint quat_t [4];
	typedef struct {
		logic op;
		q16_t hq [4];
		q16_t fq [4];
	} quat_req_t;
	typedef struct {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
		logic               clamped;
	} euler_t;

	logic clk, arst_n, start, busy, op, cfg_we, done, pitch_clamped;
	q16_t hand_w, hand_x, hand_y, hand_z, fore_w, fore_x, fore_y, fore_z;
	logic [2:0] cfg_idx;
	logic [15:0] cfg_wdata;
	logic signed [15:0] yaw, roll;
	logic signed [14:0] pitch;

	quat_req_t request_q [$];
	euler_t angle_q [$];
	quat_req_t cur;
	longint zero_q [4];
	int fails = 0;
	int gap_left = 0;
	int cycles = 0;
	bit steady = 0;

	relative_quaternion_to_euler #(.CORDIC_ITERS(ITERS)) u_dut (.*);

	always #4 clk = ~clk;

	function automatic longint to_q14(longint s);
		longint v;
		v = (s + 8192) >>> 14;
		return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
	endfunction

	function automatic quat_t conj_mul(quat_t a, quat_t b);
		quat_t r;
		longint aw, ax, ay, az;
		aw = a[0]; ax = -a[1]; ay = -a[2]; az = -a[3];
		r[0] = to_q14(aw * b[0] - ax * b[1] - ay * b[2] - az * b[3]);
		r[1] = to_q14(aw * b[1] + ax * b[0] + ay * b[3] - az * b[2]);
		r[2] = to_q14(aw * b[2] - ax * b[3] + ay * b[0] + az * b[1]);
		r[3] = to_q14(aw * b[3] + ax * b[2] - ay * b[1] + az * b[0]);
		return r;
	endfunction

	function automatic longint unsigned root56(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint atan2_cdeg(longint y, longint x);
		longint ang, t, nx, ny;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; ang = 90 * 25600;
			end else begin
				t = x; x = -y; y = t; ang = -90 * 25600;
			end
		end
		for (int i = 0; i < ITERS && i < TAB_LEN; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); ang += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); ang -= longint'(ATAN_TAB[i]);
			end
			x = nx; y = ny;
		end
		ang = (ang + 128) >>> 8;
		return ang < -18000 ? -18000 : (ang > 18000 ? 18000 : ang);
	endfunction

	function automatic euler_t predict_euler(quat_req_t r);
		quat_t h, f, d, q;
		longint sy, cy, sp, sr, cr, p, one;
		euler_t e;
		one = longint'(1) << 28;
		for (int k = 0; k < 4; k++) begin
			h[k] = r.hq[k];
			f[k] = r.fq[k];
		end
		if (r.op == OP_RELATIVE) begin
			d = conj_mul(zero_q, h);
			q = conj_mul(f, d);
		end else begin
			q = h;
		end
		sy = 2 * (q[0] * q[3] + q[1] * q[2]);
		cy = one - 2 * (q[2] * q[2] + q[3] * q[3]);
		sp = 2 * (q[0] * q[2] - q[3] * q[1]);
		sr = 2 * (q[0] * q[1] + q[2] * q[3]);
		cr = one - 2 * (q[1] * q[1] + q[2] * q[2]);
		e.yaw = 16'(atan2_cdeg(sy, cy));
		e.roll = 16'(atan2_cdeg(sr, cr));
		e.clamped = 1'b1;
		if (sp >= one) begin
			p = 9000;
		end else if (sp <= -one) begin
			p = -9000;
		end else begin
			e.clamped = 1'b0;
			p = atan2_cdeg(sp, longint'(root56((64'd1 << 56) - longint'(sp * sp))));
			p = p < -9000 ? -9000 : (p > 9000 ? 9000 : p);
		end
		e.pitch = 15'(p);
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic q16_t pick_comp(int flavor);
		case (flavor)
			0: return q16_t'($urandom);
			1: return q16_t'($urandom_range(0, 32768) - 16384);
			default: begin
				case ($urandom_range(0, 5))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return -16'sd16384;
					3: return 16'sd16384;
					4: return 16'sd0;
					default: return q16_t'($urandom_range(0, 16) - 8);
				endcase
			end
		endcase
	endfunction

	task automatic push_req(logic o, q16_t hw, q16_t hx, q16_t hy, q16_t hz,
			q16_t fw, q16_t fx, q16_t fy, q16_t fz);
		quat_req_t r;
		r.op = o;
		r.hq = '{hw, hx, hy, hz};
		r.fq = '{fw, fx, fy, fz};
		request_q.push_back(r);
	endtask

	task automatic push_random(int n);
		quat_req_t r;
		int flavor;
		repeat (n) begin
			flavor = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
			r.op = $urandom_range(0, 1) ? OP_RELATIVE : OP_DIRECT;
			for (int k = 0; k < 4; k++) begin
				r.hq[k] = pick_comp(flavor);
				r.fq[k] = pick_comp(flavor);
			end
			request_q.push_back(r);
		end
	endtask

	task automatic drain();
		wait (request_q.size() == 0 && !start && angle_q.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		if (idx <= REG_ZERO_Z) zero_q[idx] = longint'($signed(val));
	endtask

	task automatic load_zero(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		cfg_write(REG_ZERO_W, w);
		cfg_write(REG_ZERO_X, x);
		cfg_write(REG_ZERO_Y, y);
		cfg_write(REG_ZERO_Z, z);
		// out-of-range index must be ignored
		cfg_write(cfg_reg_t'($urandom_range(4, 7)), 16'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (start && !busy) angle_q.push_back(predict_euler(cur));
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (request_q.size() > 0) begin
				cur = request_q.pop_front();
				op <= cur.op;
				{hand_w, hand_x, hand_y, hand_z} <= {cur.hq[0], cur.hq[1], cur.hq[2], cur.hq[3]};
				{fore_w, fore_x, fore_y, fore_z} <= {cur.fq[0], cur.fq[1], cur.fq[2], cur.fq[3]};
				start <= 1'b1;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && done) begin
			if (angle_q.size() == 0) begin
				$error("unexpected result: yaw %0d pitch %0d roll %0d", yaw, pitch, roll);
				fails++;
			end else begin
				e = angle_q.pop_front();
				if (yaw !== e.yaw) begin
					$error("yaw expected %0d actual %0d", e.yaw, yaw);
					fails++;
				end
				if (pitch !== e.pitch) begin
					$error("pitch expected %0d actual %0d", e.pitch, pitch);
					fails++;
				end
				if (roll !== e.roll) begin
					$error("roll expected %0d actual %0d", e.roll, roll);
					fails++;
				end
				if (pitch_clamped !== e.clamped) begin
					$error("pitch_clamped expected %0d actual %0d", e.clamped, pitch_clamped);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		start = 0;
		op = OP_DIRECT;
		{hand_w, hand_x, hand_y, hand_z, fore_w, fore_x, fore_y, fore_z} = '0;
		cfg_we = 0;
		cfg_idx = REG_ZERO_W;
		cfg_wdata = '0;
		zero_q = '{longint'(ZERO_W_RST), 0, 0, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity, both atan2 args zero, left half-plane, pitch saturation both ways
		push_req(OP_DIRECT, 16384, 0, 0, 0, 16384, 0, 0, 0);
		push_req(OP_DIRECT, 0, 0, 8192, 8192, 0, 0, 0, 0);
		push_req(OP_DIRECT, 0, 0, 0, 16384, 0, 0, 0, 0);
		push_req(OP_DIRECT, 0, 16384, 0, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 0, -16384, -1, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 16384, 0, 8192, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 16384, 0, -8192, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 16384, 0, 8191, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 11585, 0, 11585, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, 0, 0, 0, 0, 0, 0, 0, 0);
		push_req(OP_DIRECT, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
		push_req(OP_DIRECT, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
		push_req(OP_DIRECT, 32767, -32768, 32767, -32768, 0, 0, 0, 0);
		push_req(OP_RELATIVE, 16384, 0, 0, 0, 16384, 0, 0, 0);
		push_req(OP_RELATIVE, 11585, 11585, 0, 0, 11585, 0, 0, 11585);
		push_req(OP_RELATIVE, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		push_req(OP_RELATIVE, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		push_req(OP_RELATIVE, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
		push_req(OP_RELATIVE, 0, 0, 0, 0, 16384, 0, 0, 0);
		push_req(OP_RELATIVE, 16384, 0, 8192, 0, 16384, 0, 0, 0);
		steady = 1;
		push_random(PHASE_ITEMS / 2);
		drain();
		steady = 0;
		push_random(PHASE_ITEMS / 2);
		drain();

		load_zero(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_random(PHASE_ITEMS);
		drain();

		load_zero(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		push_random(PHASE_ITEMS);
		drain();

		load_zero(16'(pick_comp(1)), 16'(pick_comp(1)), 16'(pick_comp(1)), 16'(pick_comp(1)));
		steady = 1;
		push_random(PHASE_ITEMS / 3);
		drain();
		steady = 0;
		push_random(PHASE_ITEMS);
		drain();

		load_zero(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		push_random(PHASE_ITEMS);
		drain();

		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/rqe_pkg.sv
design/rqe_qmul.sv
design/rqe_cordic.sv
design/relative_quaternion_to_euler.sv
design/rqe_checker.sv
verif/relative_quaternion_to_euler_test.sv
